[rtl/core/lorentzian_residual_jacobian_unit_defines.svh]
// Assertion macros shared by the Lorentzian residual and Jacobian unit.
`ifndef LORENTZIAN_RESIDUAL_JACOBIAN_UNIT_DEFINES_SVH
`define LORENTZIAN_RESIDUAL_JACOBIAN_UNIT_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define LRJ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The condition never holds.
`define LRJ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

[rtl/core/lrj_pkg.sv]
// Types and constants of the Lorentzian residual and Jacobian unit.
package lrj_pkg;

    localparam int DW = 32;             // data width of every Q16.16 field
    localparam int FB = 16;             // fraction bits
    localparam int DQ = 49;             // quotient bits of the divisions by D
    localparam int RW = 65;             // width of D
    localparam int NW = RW + DQ;        // remainder plus numerator of a D division
    localparam int SQ = 32;             // quotient bits of the divisions by the error
    localparam int SW = 63;             // remainder plus numerator of an error division
    localparam int NLANE = 6;           // numeric result fields
    localparam int QDEPTH = 4;          // entries of the queue between front and back
    localparam int QAW = 2;             // index width of that queue

    localparam logic [DW-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] LIM_NEG = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_OFFSET,
        REG_SLOPE,
        REG_HEIGHT,
        REG_CENTRE,
        REG_WIDTH
    } reg_idx_t;

    typedef enum logic [2:0] {
        LANE_RESIDUAL,
        LANE_OFFSET,
        LANE_SLOPE,
        LANE_HEIGHT,
        LANE_CENTRE,
        LANE_WIDTH
    } lane_t;

    // Configuration as the datapath sees it; w already has zero replaced by one step.
    typedef struct packed {
        logic signed [DW-1:0] b0;
        logic signed [DW-1:0] b1;
        logic signed [DW-1:0] h;
        logic signed [DW-1:0] c;
        logic [DW-2:0]        w;
    } cfg_t;

    // One classified data point.
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic [DW-2:0]        s;
        logic                 last;
        logic                 bad;
        logic                 dneg;
        logic                 xneg;
        logic [DW-1:0]        ad;
        logic [DW-1:0]        xm;
    } item_t;

    // Side data carried through the divisions by D.
    typedef struct packed {
        logic [DW-2:0]        s;
        logic                 last;
        logic                 bad;
        logic                 dneg;
        logic                 xneg;
        logic [DW-1:0]        xm;
        logic [63:0]          mb;
    } ctx_t;

    // Side data carried through the divisions by the error.
    typedef struct packed {
        logic [DW-2:0]        s;
        logic                 last;
        logic                 bad;
    } sctx_t;

endpackage

[rtl/core/lrj_queue.sv]
// Short queue of classified points between the front and the back.
module lrj_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lrj_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lrj_pkg::item_t head_item
);
    import lrj_pkg::*;

    item_t           mem_reg [0:QDEPTH-1];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QAW'(push);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/lrj_front.sv]
// Front end: takes input beats and classifies each point for the back end.
module lrj_front (
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [31:0]     s_x_value,
    input  logic signed [31:0]     s_y_value,
    input  logic [30:0]            s_y_error,
    input  logic                   s_last_point,
    input  lrj_pkg::cfg_t          cfg,
    input  logic                   q_full,
    output logic                   q_push,
    output lrj_pkg::item_t         q_item
);
    import lrj_pkg::*;

    logic signed [DW:0] d;
    logic [DW:0]        d_neg;
    logic [DW:0]        x_neg;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        d     = {s_x_value[DW-1], s_x_value} - {cfg.c[DW-1], cfg.c};
        d_neg = -d;
        x_neg = -{s_x_value[DW-1], s_x_value};

        q_item      = '0;
        q_item.x    = s_x_value;
        q_item.y    = s_y_value;
        q_item.s    = s_y_error;
        q_item.last = s_last_point;
        q_item.bad  = (s_y_error == '0);
        q_item.dneg = d[DW];
        q_item.xneg = s_x_value[DW-1];
        q_item.ad   = d[DW] ? d_neg[DW-1:0] : d[DW-1:0];
        q_item.xm   = s_x_value[DW-1] ? x_neg[DW-1:0] : s_x_value;
    end

endmodule

[rtl/core/lrj_back.sv]
// Back end: pipelined Lorentzian model, divisions and saturation.
module lrj_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  lrj_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  lrj_pkg::item_t     q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_residual,
    output logic signed [31:0] m_d_offset,
    output logic signed [31:0] m_d_slope,
    output logic signed [31:0] m_d_height,
    output logic signed [31:0] m_d_centre,
    output logic signed [31:0] m_d_width,
    output logic               m_last_out,
    output logic               m_saturated,
    output logic               m_bad_error
);
    import lrj_pkg::*;

    localparam int NS = DQ + SQ + 8;

    // One restoring step of a division by D: remainder on top, numerator bits below.
    function automatic logic [NW-1:0] dd_step(input logic [NW-1:0] a, input logic [RW-1:0] dv);
        logic [RW:0] t;
        logic [RW:0] r;
        logic        qb;
        t  = a[NW-1:DQ-1];
        qb = (t >= {1'b0, dv});
        r  = qb ? (t - {1'b0, dv}) : t;
        return {r[RW-1:0], a[DQ-2:0], qb};
    endfunction

    // One restoring step of a division by the error.
    function automatic logic [SW-1:0] s_step(input logic [SW-1:0] a, input logic [DW-2:0] dv);
        logic [DW-1:0] t;
        logic [DW-1:0] r;
        logic          qb;
        t  = a[SW-1:DW-1];
        qb = (t >= {1'b0, dv});
        r  = qb ? (t - {1'b0, dv}) : t;
        return {r[DW-2:0], a[DW-2:0], qb};
    endfunction

    logic [NS-1:0] vld_reg, vld_next;
    logic          adv;

    // Height magnitude, sign; user keeps them static while items flow, unenforced.
    logic [DW:0]   h_neg_v;
    logic [DW-1:0] hm;
    logic          hneg;

    // Stage 0: squares and slope product.
    logic [63:0]        ad2_reg;
    logic [61:0]        w2_reg;
    logic signed [63:0] bx_reg;
    item_t              it0_reg;
    logic [63:0]        ad2_c;
    logic [61:0]        w2_c;
    logic signed [63:0] bx_c;

    // Stage 1: D and the background part of the model sum.
    logic [RW-1:0]      dd1_reg;
    logic [61:0]        w2_1_reg;
    logic [63:0]        mb1_reg;
    item_t              it1_reg;
    logic signed [DW:0] by_c;

    // Divisions by D for L, d/D and w/D.
    logic [NW-1:0]  dv_reg [0:2][0:DQ];
    logic [RW-1:0]  dd_reg [0:DQ];
    ctx_t           cx_reg [0:DQ];

    // Stage E1.
    logic [63:0]  p1_reg, p2_reg;
    logic [32:0]  lq1_reg;
    logic [47:0]  gq1_reg;
    logic [48:0]  kq1_reg;
    ctx_t         ce1_reg;
    logic [32:0]  lq_c, lqc_c;

    // Stage E2.
    logic [55:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    logic [56:0]  ka_reg, kc_reg;
    logic [55:0]  kb_reg, kd_reg;
    logic [63:0]  m2_reg;
    logic [32:0]  lq2_reg;
    ctx_t         ce2_reg;
    logic [63:0]  hr_c, hls_c;

    // Stage E3.
    logic [111:0] pf_reg, pw_reg;
    logic [63:0]  m3_reg;
    logic [32:0]  lq3_reg;
    ctx_t         ce3_reg;

    // Divisions by the error, one lane per numeric field.
    logic [SW-1:0]      sv_reg [0:NLANE-1][0:SQ];
    logic [NLANE-1:0]   so_reg [0:SQ];
    logic [NLANE-1:0]   sn_reg [0:SQ];
    sctx_t              sx_reg [0:SQ];
    logic [63:0]        a_c [0:NLANE-1];
    logic [NLANE-1:0]   ovf_c;
    logic [NLANE-1:0]   neg_c;
    logic [63:0]        mabs_c;
    logic [112:0]       sf_c, sw_c;

    // Final stage: output register.
    logic [DW-1:0]  out_reg [0:NLANE-1];
    logic           last_reg, sat_reg, bad_reg;
    logic [DW-1:0]  out_c [0:NLANE-1];
    logic [NLANE-1:0] clip_c;

    assign adv      = !vld_reg[NS-1] || m_ready;
    assign q_pop    = adv && q_valid;
    assign vld_next = {vld_reg[NS-2:0], q_pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        h_neg_v = -{cfg.h[DW-1], cfg.h};
        hneg    = cfg.h[DW-1];
        hm      = hneg ? h_neg_v[DW-1:0] : cfg.h;
        ad2_c   = q_item.ad * q_item.ad;
        w2_c    = cfg.w * cfg.w;
        bx_c    = cfg.b1 * q_item.x;
        by_c    = {cfg.b0[DW-1], cfg.b0} - {it0_reg.y[DW-1], it0_reg.y};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ad2_reg  <= ad2_c;
            w2_reg   <= w2_c;
            bx_reg   <= bx_c;
            it0_reg  <= q_item;

            dd1_reg  <= {1'b0, ad2_reg} + {3'b0, w2_reg};
            w2_1_reg <= w2_reg;
            it1_reg  <= it0_reg;
            mb1_reg  <= bx_reg + {{15{by_c[DW]}}, by_c, 16'b0};
        end
    end

    // Numerators are rounded by adding half of D before the division.
    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0][0] <= NW'({w2_1_reg, 32'b0}) + NW'(dd1_reg[RW-1:1]);
            dv_reg[1][0] <= NW'({it1_reg.ad, 48'b0}) + NW'(dd1_reg[RW-1:1]);
            dv_reg[2][0] <= NW'({cfg.w, 48'b0}) + NW'(dd1_reg[RW-1:1]);
            dd_reg[0]    <= dd1_reg;
            cx_reg[0].s    <= it1_reg.s;
            cx_reg[0].last <= it1_reg.last;
            cx_reg[0].bad  <= it1_reg.bad;
            cx_reg[0].dneg <= it1_reg.dneg;
            cx_reg[0].xneg <= it1_reg.xneg;
            cx_reg[0].xm   <= it1_reg.xm;
            cx_reg[0].mb   <= mb1_reg;
            for (int j = 1; j <= DQ; j++) begin
                for (int l = 0; l < 3; l++) begin
                    dv_reg[l][j] <= dd_step(dv_reg[l][j-1], dd_reg[j-1]);
                end
                dd_reg[j] <= dd_reg[j-1];
                cx_reg[j] <= cx_reg[j-1];
            end
        end
    end

    always_comb begin
        lq_c  = dv_reg[0][DQ][32:0];
        lqc_c = 33'h1_0000_0000 - lq_c;
        hr_c  = p1_reg + 64'h8000;
        hls_c = hneg ? -{16'b0, hr_c[63:16]} : {16'b0, hr_c[63:16]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg  <= hm * lq_c;
            p2_reg  <= hm * lqc_c;
            lq1_reg <= lq_c;
            gq1_reg <= dv_reg[1][DQ][47:0];
            kq1_reg <= dv_reg[2][DQ][48:0];
            ce1_reg <= cx_reg[DQ];

            pa_reg  <= p1_reg[31:0] * gq1_reg[23:0];
            pb_reg  <= p1_reg[31:0] * gq1_reg[47:24];
            pc_reg  <= p1_reg[63:32] * gq1_reg[23:0];
            pd_reg  <= p1_reg[63:32] * gq1_reg[47:24];
            ka_reg  <= p2_reg[31:0] * kq1_reg[24:0];
            kb_reg  <= p2_reg[31:0] * kq1_reg[48:25];
            kc_reg  <= p2_reg[63:32] * kq1_reg[24:0];
            kd_reg  <= p2_reg[63:32] * kq1_reg[48:25];
            m2_reg  <= hls_c + ce1_reg.mb;
            lq2_reg <= lq1_reg;
            ce2_reg <= ce1_reg;

            pf_reg  <= 112'(pa_reg) + (112'(pb_reg) << 24) + (112'(pc_reg) << 32)
                     + (112'(pd_reg) << 56);
            pw_reg  <= 112'(ka_reg) + (112'(kb_reg) << 25) + (112'(kc_reg) << 32)
                     + (112'(kd_reg) << 57);
            m3_reg  <= m2_reg;
            lq3_reg <= lq2_reg;
            ce3_reg <= ce2_reg;
        end
    end

    // Each field is floor(A / s), with rounding folded into A.
    always_comb begin
        mabs_c = m3_reg[63] ? -m3_reg : m3_reg;
        sf_c   = {1'b0, pf_reg} + 113'({ce3_reg.s, 46'b0});
        sw_c   = {1'b0, pw_reg} + 113'({ce3_reg.s, 46'b0});
        a_c[LANE_RESIDUAL] = mabs_c + 64'(ce3_reg.s[DW-2:1]);
        a_c[LANE_OFFSET]   = 64'h1_0000_0000 + 64'(ce3_reg.s[DW-2:1]);
        a_c[LANE_SLOPE]    = 64'({ce3_reg.xm, 16'b0}) + 64'(ce3_reg.s[DW-2:1]);
        a_c[LANE_HEIGHT]   = 64'(lq3_reg) + 64'(ce3_reg.s[DW-2:1]);
        a_c[LANE_CENTRE]   = sf_c[110:47];
        a_c[LANE_WIDTH]    = sw_c[110:47];
        for (int l = 0; l < NLANE; l++) begin
            ovf_c[l] = (a_c[l][63:32] >= {1'b0, ce3_reg.s});
        end
        neg_c = '0;
        neg_c[LANE_RESIDUAL] = m3_reg[63];
        neg_c[LANE_SLOPE]    = ce3_reg.xneg;
        neg_c[LANE_CENTRE]   = hneg ^ ce3_reg.dneg;
        neg_c[LANE_WIDTH]    = hneg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < NLANE; l++) begin
                sv_reg[l][0] <= a_c[l][SW-1:0];
            end
            so_reg[0]      <= ovf_c;
            sn_reg[0]      <= neg_c;
            sx_reg[0].s    <= ce3_reg.s;
            sx_reg[0].last <= ce3_reg.last;
            sx_reg[0].bad  <= ce3_reg.bad;
            for (int j = 1; j <= SQ; j++) begin
                for (int l = 0; l < NLANE; l++) begin
                    sv_reg[l][j] <= s_step(sv_reg[l][j-1], sx_reg[j-1].s);
                end
                so_reg[j] <= so_reg[j-1];
                sn_reg[j] <= sn_reg[j-1];
                sx_reg[j] <= sx_reg[j-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            logic [DW-1:0] q;
            logic [DW-1:0] lim;
            logic [DW-1:0] mag;
            q         = sv_reg[l][SQ][DW-1:0];
            lim       = sn_reg[SQ][l] ? LIM_NEG : LIM_POS;
            clip_c[l] = so_reg[SQ][l] || (q > lim);
            mag       = clip_c[l] ? lim : q;
            out_c[l]  = sx_reg[SQ].bad ? '0 : (sn_reg[SQ][l] ? -mag : mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < NLANE; l++) begin
                out_reg[l] <= out_c[l];
            end
            last_reg <= sx_reg[SQ].last;
            bad_reg  <= sx_reg[SQ].bad;
            sat_reg  <= !sx_reg[SQ].bad && (clip_c != '0);
        end
    end

    assign m_valid     = vld_reg[NS-1];
    assign m_residual  = out_reg[LANE_RESIDUAL];
    assign m_d_offset  = out_reg[LANE_OFFSET];
    assign m_d_slope   = out_reg[LANE_SLOPE];
    assign m_d_height  = out_reg[LANE_HEIGHT];
    assign m_d_centre  = out_reg[LANE_CENTRE];
    assign m_d_width   = out_reg[LANE_WIDTH];
    assign m_last_out  = last_reg;
    assign m_saturated = sat_reg;
    assign m_bad_error = bad_reg;

endmodule

[rtl/core/lorentzian_residual_jacobian_unit.sv]
// Top level of the Lorentzian residual and Jacobian unit with its register port.
// Throughput: one point per cycle while the result side does not stall, set by the fully
// pipelined bit-per-stage dividers (49 stages dividing by D, 32 stages dividing by the error).
// A four-entry queue keeps the input ready while the result side stalls, until the queue fills.
// Reset (aresetn low, synchronous) empties the pipeline and queue and restores the registers.
`include "lorentzian_residual_jacobian_unit_defines.svh"
module lorentzian_residual_jacobian_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_x_value,
    input  logic signed [31:0] s_y_value,
    input  logic [30:0]        s_y_error,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_residual,
    output logic signed [31:0] m_d_offset,
    output logic signed [31:0] m_d_slope,
    output logic signed [31:0] m_d_height,
    output logic signed [31:0] m_d_centre,
    output logic signed [31:0] m_d_width,
    output logic               m_last_out,
    output logic               m_saturated,
    output logic               m_bad_error
);
    import lrj_pkg::*;

    logic [31:0] offset_reg, slope_reg, height_reg, centre_reg;
    logic [30:0] width_reg;
    logic        wr_en;
    reg_idx_t    idx;
    cfg_t        cfg;
    logic        q_full, q_push, q_pop, q_valid;
    item_t       push_item, head_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            slope_reg  <= '0;
            height_reg <= '0;
            centre_reg <= '0;
            width_reg  <= 31'd65536;
        end else if (wr_en) begin
            unique case (idx)
                REG_OFFSET: offset_reg <= pwdata;
                REG_SLOPE:  slope_reg  <= pwdata;
                REG_HEIGHT: height_reg <= pwdata;
                REG_CENTRE: centre_reg <= pwdata;
                REG_WIDTH:  width_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_OFFSET: prdata = offset_reg;
            REG_SLOPE:  prdata = slope_reg;
            REG_HEIGHT: prdata = height_reg;
            REG_CENTRE: prdata = centre_reg;
            REG_WIDTH:  prdata = {1'b0, width_reg};
            default:    prdata = '0;
        endcase
    end

    // A zero half width acts as the smallest step.
    always_comb begin
        cfg.b0 = offset_reg;
        cfg.b1 = slope_reg;
        cfg.h  = height_reg;
        cfg.c  = centre_reg;
        cfg.w  = (width_reg == '0) ? 31'd1 : width_reg;
    end

    lrj_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_x_value    (s_x_value),
        .s_y_value    (s_y_value),
        .s_y_error    (s_y_error),
        .s_last_point (s_last_point),
        .cfg          (cfg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    lrj_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    lrj_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_residual  (m_residual),
        .m_d_offset  (m_d_offset),
        .m_d_slope   (m_d_slope),
        .m_d_height  (m_d_height),
        .m_d_centre  (m_d_centre),
        .m_d_width   (m_d_width),
        .m_last_out  (m_last_out),
        .m_saturated (m_saturated),
        .m_bad_error (m_bad_error)
    );

    `LRJ_ASSERT_IMPLY(a_bad_zero, m_valid && m_bad_error, m_residual == 0 && m_d_width == 0 && m_d_centre == 0, "zero error beat carries nonzero data")
    `LRJ_ASSERT_IMPLY(a_offset_sign, m_valid && !m_bad_error, !m_d_offset[31], "offset derivative is negative")
    `LRJ_ASSERT_NEVER(a_flags, m_valid && m_bad_error && m_saturated, "saturation flagged on a zero error beat")

endmodule

[verif/lorentzian_residual_jacobian_unit_checker.sv]
// Checker for the Lorentzian unit: tracks register writes, predicts each result beat, compares.
module lorentzian_residual_jacobian_unit_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_x_value,
    input  logic signed [31:0] s_y_value,
    input  logic [30:0]        s_y_error,
    input  logic               s_last_point,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_residual,
    input  logic signed [31:0] m_d_offset,
    input  logic signed [31:0] m_d_slope,
    input  logic signed [31:0] m_d_height,
    input  logic signed [31:0] m_d_centre,
    input  logic signed [31:0] m_d_width,
    input  logic               m_last_out,
    input  logic               m_saturated,
    input  logic               m_bad_error,
    output int                 fail_count,
    output int                 pending
);
    import lrj_pkg::*;

    typedef struct packed {
        logic [NLANE-1:0][31:0] lane;
        logic                   last;
        logic                   sat;
        logic                   bad;
    } fit_result_t;

    logic signed [31:0] bg_offset, bg_slope, pk_height, pk_centre;
    logic [30:0]        hw;
    fit_result_t        fit_q[$];
    int                 n_in, n_out;

    assign pending = n_in - n_out;

    // Quotient rounded to nearest with halves away from zero; zero divisor gives zero.
    function automatic logic [127:0] round_div(logic [127:0] n, logic [127:0] dv);
        if (dv == 0) return '0;
        return (n + (dv >> 1)) / dv;
    endfunction

    function automatic logic [31:0] clip_q16(logic neg, logic [127:0] mag, inout logic sat);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag > lim) begin
            sat = 1'b1;
            mag = lim;
        end
        return neg ? 32'(-mag) : mag[31:0];
    endfunction

    function automatic fit_result_t predict_point(logic signed [31:0] x, logic signed [31:0] y,
                                                  logic [30:0] s, logic last);
        fit_result_t r;
        longint d, hls, m, xs, ys;
        logic dneg, hneg, xneg, sat;
        logic [127:0] ad, hm, xm, w, dd, lq, gq, kq, hl, sw, sbig, am, hml, hmc;
        r = '0;
        r.last = last;
        if (s == 0) begin
            r.bad = 1'b1;
            return r;
        end
        sat = 1'b0;
        xs = longint'(x);
        ys = longint'(y);
        d = xs - longint'(pk_centre);
        dneg = d < 0;
        hneg = pk_height < 0;
        xneg = x < 0;
        ad = dneg ? 128'(-d) : 128'(d);
        hm = hneg ? 128'(-longint'(pk_height)) : 128'(pk_height);
        xm = xneg ? 128'(-xs) : 128'(xs);
        w = (hw == 0) ? 128'd1 : 128'(hw);
        dd = ad * ad + w * w;
        lq = 128'(64'(round_div((w * w) << 32, dd)));
        gq = 128'(64'(round_div(ad << (FB + 32), dd)));
        kq = 128'(64'(round_div(w << (FB + 32), dd)));
        hl = ((hm * lq) + (128'd1 << (31 - FB))) >> (32 - FB);
        hls = hneg ? -longint'(hl[63:0]) : longint'(hl[63:0]);
        m = hls + longint'(bg_slope) * xs + (longint'(bg_offset) - ys) * (longint'(1) << FB);
        am = (m < 0) ? 128'(-m) : 128'(m);
        sw = 128'(s);
        sbig = sw << (64 - FB);
        hml = 128'(64'(hm * lq));
        hmc = 128'(64'(hm * ((128'd1 << 32) - lq)));
        r.lane[LANE_RESIDUAL] = clip_q16(m < 0, round_div(am, sw), sat);
        r.lane[LANE_OFFSET]   = clip_q16(1'b0, round_div(128'd1 << (2 * FB), sw), sat);
        r.lane[LANE_SLOPE]    = clip_q16(xneg, round_div(xm << FB, sw), sat);
        r.lane[LANE_HEIGHT]   = clip_q16(1'b0, round_div(lq << (2 * FB), sw << 32), sat);
        r.lane[LANE_CENTRE]   = clip_q16(hneg != dneg, round_div((hml * gq) << 1, sbig), sat);
        r.lane[LANE_WIDTH]    = clip_q16(hneg, round_div((hmc * kq) << 1, sbig), sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        fit_result_t exp_r;
        if (!aresetn) begin
            bg_offset <= '0;
            bg_slope  <= '0;
            pk_height <= '0;
            pk_centre <= '0;
            hw        <= 31'd65536;
            fit_q.delete();
            n_in       <= 0;
            n_out      <= 0;
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_OFFSET: bg_offset <= pwdata;
                    REG_SLOPE:  bg_slope  <= pwdata;
                    REG_HEIGHT: pk_height <= pwdata;
                    REG_CENTRE: pk_centre <= pwdata;
                    REG_WIDTH:  hw        <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                fit_q.push_back(predict_point(s_x_value, s_y_value, s_y_error, s_last_point));
                n_in <= n_in + 1;
            end
            if (m_valid && m_ready) begin
                n_out <= n_out + 1;
                if (fit_q.size() == 0) begin
                    $error("result beat with no point outstanding");
                    fail_count++;
                end else begin
                    exp_r = fit_q.pop_front();
                    compare_field("residual", exp_r.lane[LANE_RESIDUAL], m_residual);
                    compare_field("d_offset", exp_r.lane[LANE_OFFSET], m_d_offset);
                    compare_field("d_slope", exp_r.lane[LANE_SLOPE], m_d_slope);
                    compare_field("d_height", exp_r.lane[LANE_HEIGHT], m_d_height);
                    compare_field("d_centre", exp_r.lane[LANE_CENTRE], m_d_centre);
                    compare_field("d_width", exp_r.lane[LANE_WIDTH], m_d_width);
                    compare_field("last_out", 32'(exp_r.last), 32'(m_last_out));
                    compare_field("saturated", 32'(exp_r.sat), 32'(m_saturated));
                    compare_field("bad_error", 32'(exp_r.bad), 32'(m_bad_error));
                end
            end
        end
    end

endmodule

[verif/lorentzian_residual_jacobian_unit_tb.sv]
// Testbench top for the Lorentzian unit: clock, reset, register setup, point and result traffic.
module lorentzian_residual_jacobian_unit_tb;
    import lrj_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_x_value = '0, s_y_value = '0;
    logic [30:0]        s_y_error = '0;
    logic               s_last_point = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_residual, m_d_offset, m_d_slope, m_d_height, m_d_centre, m_d_width;
    logic               m_last_out, m_saturated, m_bad_error;
    int                 fail_count, pending;
    logic               no_idle = 1'b0;
    logic               hold_req = 1'b0;
    int                 points_sent = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    lorentzian_residual_jacobian_unit u_dut (.*);

    lorentzian_residual_jacobian_unit_checker u_chk (.*);

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_model(logic [31:0] b0, logic [31:0] b1, logic [31:0] h,
                             logic [31:0] c, logic [31:0] w);
        reg_write(REG_OFFSET, b0);
        reg_write(REG_SLOPE, b1);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_CENTRE, c);
        reg_write(REG_WIDTH, w);
    endtask

    // Waits until every point has produced its result and the pipe has drained.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [30:0] s, logic last);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_x_value    <= x;
        s_y_value    <= y;
        s_y_error    <= s;
        s_last_point <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        points_sent++;
    endtask

    task automatic send_random(int n);
        logic [31:0] x, y;
        logic [30:0] s;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    x = $urandom();
                    y = $urandom();
                    s = 31'($urandom());
                end
                default: begin
                    x = 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
                    y = 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
                    s = 31'($urandom_range(32'h0000_1000, 32'h0004_0000));
                end
            endcase
            if ($urandom_range(0, 49) == 0) s = '0;
            send_point(x, y, s, $urandom_range(0, 15) == 0);
        end
    endtask

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        bit held = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                held = 1;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points on reset registers: field extremes, zero error, point at the centre.
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 31'd1, 1'b1);
        send_point(32'h0001_0000, 32'h0000_8000, 31'd0, 1'b1);
        send_point(32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 31'h4000_0000, 1'b0);
        drain_pipe();

        set_model(32'h0001_8000, 32'h0000_4000, 32'h000A_0000, 32'h0002_0000, 32'h0000_8000);
        send_point(32'h0002_0000, 32'h000B_0000, 31'h0001_0000, 1'b0);
        send_point(32'h0002_8000, 32'h0005_0000, 31'h0000_8000, 1'b0);
        send_point(32'h0001_8000, 32'h0005_0000, 31'd1, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000, 1'b0);
        send_random(450);
        drain_pipe();

        // Dip with a zero half width, which the block treats as one raw step.
        set_model(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h0, 31'h0001_0000, 1'b0);
        send_point(32'h7FFF_FFFE, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 1'b0);
        send_random(150);
        drain_pipe();

        set_model(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 31'h0000_0100, 1'b0);
        send_point(32'h0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_random(150);
        drain_pipe();

        // Moderate random model; the result side holds off while points keep coming.
        set_model(32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000),
                  32'($signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000),
                  32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000),
                  32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000),
                  32'($urandom_range(32'h0000_0100, 32'h0004_0000)));
        hold_req <= 1'b1;
        send_random(400);
        drain_pipe();

        set_model($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        send_random(100);
        no_idle <= 1'b1;
        send_random(250);
        drain_pipe();

        $display("Sent %0d points over six register settings, including extremes,",
                 points_sent);
        $display("zero errors, zero half width, stall bursts and a long result hold-off.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lrj_pkg.sv
rtl/core/lrj_queue.sv
rtl/core/lrj_front.sv
rtl/core/lrj_back.sv
rtl/core/lorentzian_residual_jacobian_unit.sv
verif/lorentzian_residual_jacobian_unit_checker.sv
verif/lorentzian_residual_jacobian_unit_tb.sv
